[rtl/pru_pkg.sv]
// Shared constants, codes and control types of the palette RGB565 upscaler.
`default_nettype none

package pru_pkg;

   // Source image geometry and palette size.
   localparam int SRC_WIDTH     = 320;
   localparam int PALETTE_DEPTH = 256;

   // The doubled framebuffer is twice the source width; one source row covers two lines.
   localparam int LINE_PITCH = 2 * SRC_WIDTH;
   localparam int ROW_PITCH  = 2 * LINE_PITCH;

   // Field widths of the transactions.
   localparam int OP_W     = 2;
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 8;
   localparam int COLUMN_W = 9;
   localparam int ROW_W    = 8;
   localparam int CHAN_W   = 8;
   localparam int OFFSET_W = 18;
   localparam int COLOR_W  = 16;

   // Squared channel difference and the sum of three of them.
   localparam int SQ_W   = 16;
   localparam int DIFF_W = 18;

   // Operation codes of an input transaction.
   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_CONVERT = 2'd1,
      OP_SEARCH  = 2'd2,
      OP_NONE    = 2'd3
   } pru_op_type;

   // Kinds of result transaction.
   typedef enum logic [KIND_W-1:0] {
      KIND_FB     = 2'd0,
      KIND_ACK    = 2'd1,
      KIND_ANSWER = 2'd2
   } pru_kind_type;

   // The four framebuffer writes of one doubled pixel, in output order.
   typedef enum logic [1:0] {
      BEAT_TOP_LEFT  = 2'd0,
      BEAT_TOP_RIGHT = 2'd1,
      BEAT_BOT_LEFT  = 2'd2,
      BEAT_BOT_RIGHT = 2'd3
   } pru_beat_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         pal_write;
      logic         conv_read;
      logic         scan_start;
      logic         scan_step;
      logic         out_load;
      pru_kind_type out_kind;
      pru_beat_type beat;
      logic         out_last;
   } pru_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
      logic scan_last;
      logic zero_hit;
      logic pipe_busy;
   } pru_stat_type;

endpackage

`default_nettype wire

[rtl/pru_req_if.sv]
// Request channel interface: valid/ready handshake with the input transaction fields.
`default_nettype none

interface pru_req_if;

   logic                         valid;
   logic                         ready;
   logic [pru_pkg::OP_W-1:0]     operation;
   logic [pru_pkg::INDEX_W-1:0]  entry_index;
   logic [pru_pkg::COLUMN_W-1:0] column;
   logic [pru_pkg::ROW_W-1:0]    row;
   logic [pru_pkg::CHAN_W-1:0]   red;
   logic [pru_pkg::CHAN_W-1:0]   green;
   logic [pru_pkg::CHAN_W-1:0]   blue;

   modport source (
      output valid, operation, entry_index, column, row, red, green, blue,
      input  ready
   );

   modport sink (
      input  valid, operation, entry_index, column, row, red, green, blue,
      output ready
   );

endinterface

`default_nettype wire

[rtl/pru_rsp_if.sv]
// Response channel interface: valid/ready handshake with the result transaction fields.
`default_nettype none

interface pru_rsp_if;

   logic                         valid;
   logic                         ready;
   logic [pru_pkg::KIND_W-1:0]   result_kind;
   logic [pru_pkg::OFFSET_W-1:0] fb_offset;
   logic [pru_pkg::COLOR_W-1:0]  pixel_color;
   logic [pru_pkg::INDEX_W-1:0]  nearest_index;
   logic                         last;

   modport source (
      output valid, result_kind, fb_offset, pixel_color, nearest_index, last,
      input  ready
   );

   modport sink (
      input  valid, result_kind, fb_offset, pixel_color, nearest_index, last,
      output ready
   );

endinterface

`default_nettype wire

[rtl/pru_ctrl.sv]
// Controller state machine: sequences palette writes, pixel doubling and the color search.
`default_nettype none

module pru_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  pru_pkg::pru_op_type  req_operation,
   output logic                 req_ready,
   input  pru_pkg::pru_stat_type stat,
   output pru_pkg::pru_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ACK    = 6'b000010,
      ST_CONV   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_ANSWER = 6'b100000
   } pru_state_type;

   pru_state_type         state_ff;
   pru_state_type         state_in;
   pru_pkg::pru_beat_type beat_ff;
   pru_pkg::pru_beat_type beat_in;
   logic                  accept;

   // A new transaction is taken only between operations.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      beat_in      = beat_ff;
      cmd          = '0;
      cmd.out_kind = pru_pkg::KIND_FB;
      cmd.beat     = beat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (req_operation)
                  pru_pkg::OP_WRITE: begin
                     cmd.pal_write = 1'b1;
                     state_in      = ST_ACK;
                  end
                  pru_pkg::OP_CONVERT: begin
                     cmd.conv_read = 1'b1;
                     beat_in       = pru_pkg::BEAT_TOP_LEFT;
                     state_in      = ST_CONV;
                  end
                  pru_pkg::OP_SEARCH: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACK: begin
            if (stat.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = pru_pkg::KIND_ACK;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CONV: begin
            if (stat.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = pru_pkg::KIND_FB;
               cmd.out_last = (beat_ff == pru_pkg::BEAT_BOT_RIGHT);
               beat_in      = pru_pkg::pru_beat_type'(beat_ff + 2'd1);
               if (beat_ff == pru_pkg::BEAT_BOT_RIGHT) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            // An exact match ends the sweep; nothing after it can win.
            if (stat.zero_hit) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.scan_step = 1'b1;
               if (stat.scan_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_ANSWER;
            end
         end
         ST_ANSWER: begin
            if (stat.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = pru_pkg::KIND_ANSWER;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         beat_ff  <= pru_pkg::BEAT_TOP_LEFT;
      end else begin
         state_ff <= state_in;
         beat_ff  <= beat_in;
      end
   end

   // A result is only issued into a free output register.
   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.slot_free)
      else $error("result loaded while the output register is occupied");

   // An accepted palette write is always acknowledged next.
   a_write_then_ack: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == pru_pkg::OP_WRITE) |=> (state_ff == ST_ACK))
      else $error("palette write not followed by its acknowledge");

   // Once the search pipeline is empty the answer is sent.
   a_drain_to_answer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !stat.pipe_busy) |=> (state_ff == ST_ANSWER))
      else $error("search drain did not move to the answer");

endmodule

`default_nettype wire

[rtl/pru_datapath.sv]
// Datapath: palette memory, offset arithmetic, distance pipeline and the output register.
`default_nettype none

module pru_datapath #(
   parameter int PALETTE_DEPTH = pru_pkg::PALETTE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pru_pkg::pru_cmd_type          cmd,
   output pru_pkg::pru_stat_type         stat,
   input  logic [pru_pkg::INDEX_W-1:0]   entry_index,
   input  logic [pru_pkg::COLUMN_W-1:0]  column,
   input  logic [pru_pkg::ROW_W-1:0]     row,
   input  logic [pru_pkg::CHAN_W-1:0]    red,
   input  logic [pru_pkg::CHAN_W-1:0]    green,
   input  logic [pru_pkg::CHAN_W-1:0]    blue,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pru_pkg::KIND_W-1:0]    result_kind,
   output logic [pru_pkg::OFFSET_W-1:0]  fb_offset,
   output logic [pru_pkg::COLOR_W-1:0]   pixel_color,
   output logic [pru_pkg::INDEX_W-1:0]   nearest_index,
   output logic                          last
);

   localparam int ADDR_W   = $clog2(PALETTE_DEPTH);
   localparam int OFFSET_W = pru_pkg::OFFSET_W;
   localparam int COLOR_W  = pru_pkg::COLOR_W;
   localparam int CHAN_W   = pru_pkg::CHAN_W;
   localparam int SQ_W     = pru_pkg::SQ_W;
   localparam int DIFF_W   = pru_pkg::DIFF_W;

   logic [COLOR_W-1:0]  palette_ff [PALETTE_DEPTH];
   logic [COLOR_W-1:0]  rd_data_ff;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   logic [CHAN_W-1:0]   red_ff;
   logic [CHAN_W-1:0]   green_ff;
   logic [CHAN_W-1:0]   blue_ff;
   logic [COLOR_W-1:0]  packed_ff;
   logic [COLOR_W-1:0]  packed_in;
   logic                oob_ff;
   logic                oob_in;
   logic [OFFSET_W-1:0] base_ff;
   logic [OFFSET_W-1:0] base_in;

   logic [ADDR_W-1:0]   scan_addr_ff;
   logic                s1_v_ff;
   logic [ADDR_W-1:0]   s1_idx_ff;
   logic                s2_v_ff;
   logic [ADDR_W-1:0]   s2_idx_ff;
   logic [SQ_W-1:0]     sq_r_ff;
   logic [SQ_W-1:0]     sq_g_ff;
   logic [SQ_W-1:0]     sq_b_ff;
   logic [SQ_W-1:0]     sq_r_in;
   logic [SQ_W-1:0]     sq_g_in;
   logic [SQ_W-1:0]     sq_b_in;
   logic [CHAN_W-1:0]   ent_r;
   logic [CHAN_W-1:0]   ent_g;
   logic [CHAN_W-1:0]   ent_b;
   logic [CHAN_W-1:0]   dr;
   logic [CHAN_W-1:0]   dg;
   logic [CHAN_W-1:0]   db;
   logic [DIFF_W-1:0]   diff_sum;
   logic [DIFF_W-1:0]   best_diff_ff;
   logic [ADDR_W-1:0]   best_idx_ff;
   logic                zero_ff;
   logic                better;

   logic                valid_ff;
   pru_pkg::pru_kind_type kind_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [OFFSET_W-1:0] offset_in;
   logic [COLOR_W-1:0]  color_ff;
   logic [COLOR_W-1:0]  color_in;
   logic [pru_pkg::INDEX_W-1:0] nearest_ff;
   logic [pru_pkg::INDEX_W-1:0] nearest_in;
   logic                last_ff;
   logic [OFFSET_W-1:0] beat_add;
   logic [COLOR_W-1:0]  conv_color;

   // Incoming color packed to RGB565; entries past the palette are not stored.
   assign packed_in = {red[7:3], green[7:2], blue[7:3]};
   assign oob_in    = (int'(entry_index) >= PALETTE_DEPTH);

   // Top-left framebuffer offset of the doubled pixel, wrapped to the offset width.
   assign base_in = OFFSET_W'(row * pru_pkg::ROW_PITCH) + OFFSET_W'({column, 1'b0});

   // Capture of the transaction fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         red_ff    <= red;
         green_ff  <= green;
         blue_ff   <= blue;
         packed_ff <= packed_in;
         oob_ff    <= oob_in;
         base_ff   <= base_in;
      end
   end

   // Palette memory: one write port and one registered read port.
   assign rd_en   = cmd.conv_read || cmd.scan_step;
   assign rd_addr = cmd.conv_read ? entry_index[ADDR_W-1:0] : scan_addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.pal_write && !oob_in) begin
         palette_ff[entry_index[ADDR_W-1:0]] <= packed_in;
      end
      if (rd_en) begin
         rd_data_ff <= palette_ff[rd_addr];
      end
   end

   // Sweep address for the nearest-color search.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
   end

   // Entry expanded back to 8 bits per channel, and absolute channel differences.
   assign ent_r = {rd_data_ff[15:11], 3'b000};
   assign ent_g = {rd_data_ff[10:5], 2'b00};
   assign ent_b = {rd_data_ff[4:0], 3'b000};
   assign dr    = (red_ff > ent_r) ? (red_ff - ent_r) : (ent_r - red_ff);
   assign dg    = (green_ff > ent_g) ? (green_ff - ent_g) : (ent_g - green_ff);
   assign db    = (blue_ff > ent_b) ? (blue_ff - ent_b) : (ent_b - blue_ff);
   assign sq_r_in = SQ_W'(dr) * SQ_W'(dr);
   assign sq_g_in = SQ_W'(dg) * SQ_W'(dg);
   assign sq_b_in = SQ_W'(db) * SQ_W'(db);

   // Squares registered before the sum and compare.
   always_ff @(posedge clock) begin
      s1_idx_ff <= scan_addr_ff;
      s2_idx_ff <= s1_idx_ff;
      sq_r_ff   <= sq_r_in;
      sq_g_ff   <= sq_g_in;
      sq_b_ff   <= sq_b_in;
   end

   // Strictly smaller distance wins, so the first minimum is kept.
   assign diff_sum = DIFF_W'(sq_r_ff) + DIFF_W'(sq_g_ff) + DIFF_W'(sq_b_ff);
   assign better   = s2_v_ff && !zero_ff && (diff_sum < best_diff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         zero_ff      <= 1'b0;
         best_diff_ff <= '1;
      end else begin
         s1_v_ff <= cmd.scan_step;
         s2_v_ff <= s1_v_ff;
         if (cmd.scan_start) begin
            zero_ff      <= 1'b0;
            best_diff_ff <= '1;
         end else if (better) begin
            best_diff_ff <= diff_sum;
            zero_ff      <= (diff_sum == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (better) begin
         best_idx_ff <= s2_idx_ff;
      end
   end

   // Offset step of each of the four doubled writes.
   always_comb begin
      unique case (cmd.beat)
         pru_pkg::BEAT_TOP_LEFT:  beat_add = '0;
         pru_pkg::BEAT_TOP_RIGHT: beat_add = OFFSET_W'(1);
         pru_pkg::BEAT_BOT_LEFT:  beat_add = OFFSET_W'(pru_pkg::LINE_PITCH);
         pru_pkg::BEAT_BOT_RIGHT: beat_add = OFFSET_W'(pru_pkg::LINE_PITCH + 1);
         default:                 beat_add = '0;
      endcase
   end

   // An index beyond the palette converts to black.
   assign conv_color = oob_ff ? '0 : rd_data_ff;

   // Result fields by kind.
   always_comb begin
      offset_in  = '0;
      color_in   = '0;
      nearest_in = '0;
      case (cmd.out_kind)
         pru_pkg::KIND_FB: begin
            offset_in = base_ff + beat_add;
            color_in  = conv_color;
         end
         pru_pkg::KIND_ACK: begin
            color_in = packed_ff;
         end
         pru_pkg::KIND_ANSWER: begin
            nearest_in = pru_pkg::INDEX_W'(best_idx_ff);
         end
         default: begin
            offset_in = '0;
         end
      endcase
   end

   // Output register decouples the result side from the work in progress.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff    <= cmd.out_kind;
         offset_ff  <= offset_in;
         color_ff   <= color_in;
         nearest_ff <= nearest_in;
         last_ff    <= cmd.out_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign result_kind   = kind_ff;
   assign fb_offset     = offset_ff;
   assign pixel_color   = color_ff;
   assign nearest_index = nearest_ff;
   assign last          = last_ff;

   // Status back to the controller.
   assign stat.slot_free = !valid_ff || rsp_ready;
   assign stat.scan_last = (scan_addr_ff == ADDR_W'(PALETTE_DEPTH - 1));
   assign stat.zero_hit  = zero_ff;
   assign stat.pipe_busy = s1_v_ff || s2_v_ff;

   // An exact match is only flagged with a zero best distance.
   a_zero_means_exact: assert property (@(posedge clock) disable iff (reset)
      zero_ff |-> (best_diff_ff == '0))
      else $error("exact-match flag set with a nonzero best distance");

   // Within one search the best distance never grows.
   a_best_never_grows: assert property (@(posedge clock) disable iff (reset)
      !cmd.scan_start |=> (best_diff_ff <= $past(best_diff_ff)))
      else $error("best distance increased during a search");

endmodule

`default_nettype wire

[rtl/palette_rgb565_upscaler.sv]
// Top level of the palette RGB565 upscaler: controller and datapath joined by command and status.
`default_nettype none

// Holds an RGB565 palette and serves one transaction at a time. A palette write
// stores the packed color and returns one acknowledge through the acknowledge
// state and the output register. A pixel conversion reads the palette once and
// returns four framebuffer writes that double the pixel to a 2x2 block; no new
// transaction is taken until all four have been loaded into the single output
// register. A nearest-color search sweeps the palette through its one read port,
// one entry per cycle, followed by a distance pipeline of the read data, squares
// and best-distance registers; an exact match ends the sweep early. Any stall on
// the result side delays these results. Converting or searching an entry that
// was never written gives an undefined color or index.
module palette_rgb565_upscaler #(
   parameter int PALETTE_DEPTH = pru_pkg::PALETTE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   pru_req_if.sink   req_chan,
   pru_rsp_if.source rsp_chan
);

   pru_pkg::pru_cmd_type  cmd;
   pru_pkg::pru_stat_type stat;
   logic                  req_ready;

   // Operation sequencing.
   pru_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (pru_pkg::pru_op_type'(req_chan.operation)),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   assign req_chan.ready = req_ready;

   // Storage, arithmetic and the result register.
   pru_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .entry_index   (req_chan.entry_index),
      .column        (req_chan.column),
      .row           (req_chan.row),
      .red           (req_chan.red),
      .green         (req_chan.green),
      .blue          (req_chan.blue),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .result_kind   (rsp_chan.result_kind),
      .fb_offset     (rsp_chan.fb_offset),
      .pixel_color   (rsp_chan.pixel_color),
      .nearest_index (rsp_chan.nearest_index),
      .last          (rsp_chan.last)
   );

endmodule

`default_nettype wire
